[hw/rtl/cht_pkg.sv]
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types, constants and address helpers for the cache tag store.
// ----------------------------------------------------------------------------
package cht_pkg;

    // geometry
    localparam int SETS_LOG2  = 6;
    localparam int SETS       = 1 << SETS_LOG2;
    localparam int WAYS_LOG2  = 3;
    localparam int WAYS       = 1 << WAYS_LOG2;
    localparam int AGE_W      = 3;
    localparam int TAG_W      = 32;
    localparam int ADDR_W     = 32;
    localparam int LFSR_W     = 16;

    // config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
    localparam logic [AGE_W-1:0]  AGE_MAX   = 3'd7;

    // replacement policy codes, any other code behaves as fifo
    localparam logic [1:0] POL_FIFO   = 2'd0;
    localparam logic [1:0] POL_LRU    = 2'd1;
    localparam logic [1:0] POL_RANDOM = 2'd2;

    localparam logic CMD_WRITE = 1'b1;

    // config register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLK_BITS      = 3'd0,
        CFG_SET_BITS      = 3'd1,
        CFG_WAYS_LOG2     = 3'd2,
        CFG_POLICY        = 3'd3,
        CFG_WRITE_THROUGH = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [3:0] blk_bits;
        logic [2:0] set_bits;
        logic [1:0] ways_log2;
        logic [1:0] policy;
        logic       write_through;
    } t_cfg;

    // one set: tags, valid bits, lru ages and fifo pointer
    typedef struct packed {
        logic [WAYS-1:0][TAG_W-1:0] tags;
        logic [WAYS-1:0]            valid;
        logic [WAYS-1:0][AGE_W-1:0] age;
        logic [WAYS_LOG2-1:0]       fifo_ptr;
    } t_row;

    // lookup result handed to the output register
    typedef struct packed {
        logic                 hit;
        logic [SETS_LOG2-1:0] set_index;
        logic [TAG_W-1:0]     tag;
    } t_result;

    // index bit count saturated to the sets that exist
    function automatic logic [2:0] eff_set_bits(input t_cfg cfg);
        return (cfg.set_bits > 3'(SETS_LOG2)) ? 3'(SETS_LOG2) : cfg.set_bits;
    endfunction

    // way count saturated to the ways that exist
    function automatic logic [1:0] eff_ways_log2(input t_cfg cfg);
        return (cfg.ways_log2 > 2'(WAYS_LOG2)) ? 2'(WAYS_LOG2) : cfg.ways_log2;
    endfunction

    function automatic logic [SETS_LOG2-1:0] addr_set(input logic [ADDR_W-1:0] addr,
                                                      input t_cfg cfg);
        logic [ADDR_W-1:0]    sh;
        logic [SETS_LOG2-1:0] mask;
        sh   = addr >> cfg.blk_bits;
        mask = ~({SETS_LOG2{1'b1}} << eff_set_bits(cfg));
        return sh[SETS_LOG2-1:0] & mask;
    endfunction

    function automatic logic [TAG_W-1:0] addr_tag(input logic [ADDR_W-1:0] addr,
                                                  input t_cfg cfg);
        logic [4:0] sh;
        sh = 5'(cfg.blk_bits) + 5'(eff_set_bits(cfg));
        return addr >> sh;
    endfunction

    // number of ways in use, as a count
    function automatic logic [WAYS_LOG2:0] way_count(input t_cfg cfg);
        return {{WAYS_LOG2{1'b0}}, 1'b1} << eff_ways_log2(cfg);
    endfunction

    // one enable bit per way in use
    function automatic logic [WAYS-1:0] way_mask(input t_cfg cfg);
        return ~({WAYS{1'b1}} << way_count(cfg));
    endfunction

    // way number mask (ways in use minus one)
    function automatic logic [WAYS_LOG2-1:0] way_num_mask(input t_cfg cfg);
        logic [WAYS_LOG2:0] m;
        m = way_count(cfg) - {{WAYS_LOG2{1'b0}}, 1'b1};
        return m[WAYS_LOG2-1:0];
    endfunction

endpackage

[hw/rtl/cht_cfg_regs.sv]
// ----------------------------------------------------------------------------
// cht_cfg_regs
// Configuration registers: geometry, replacement policy and write policy.
// ----------------------------------------------------------------------------
module cht_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [cht_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [cht_pkg::CFG_DATA_W-1:0] i_data,
    output logic                         o_ready,
    output cht_pkg::t_cfg                o_cfg
);
    import cht_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register decode, unknown indexes are dropped
    always_comb begin
        n_cfg = r_cfg;
        if (i_valid) begin
            unique case (t_cfg_reg'(i_index))
                CFG_BLK_BITS:      n_cfg.blk_bits      = i_data[3:0];
                CFG_SET_BITS:      n_cfg.set_bits      = i_data[2:0];
                CFG_WAYS_LOG2:     n_cfg.ways_log2     = i_data[1:0];
                CFG_POLICY:        n_cfg.policy        = i_data[1:0];
                CFG_WRITE_THROUGH: n_cfg.write_through = i_data[0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blk_bits      <= 4'd4;
            r_cfg.set_bits      <= 3'd6;
            r_cfg.ways_log2     <= 2'd3;
            r_cfg.policy        <= POL_FIFO;
            r_cfg.write_through <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // a write beat is taken in any cycle
    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

endmodule

[hw/rtl/cht_set_ram.sv]
// ----------------------------------------------------------------------------
// cht_set_ram
// One row per set, registered write-first read. Per-row valid flops make
// rows that were never written read as all zero after reset.
// ----------------------------------------------------------------------------
module cht_set_ram (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [cht_pkg::SETS_LOG2-1:0]  i_rd_addr,
    input  logic                           i_we,
    input  logic [cht_pkg::SETS_LOG2-1:0]  i_wr_addr,
    input  cht_pkg::t_row                  i_wr_row,
    output cht_pkg::t_row                  o_rd_row
);
    import cht_pkg::*;

    t_row            mem [SETS];
    logic [SETS-1:0] r_row_ok;
    t_row            r_rd_row;

    // row array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_row;
        end
    end

    // row written since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (i_we) begin
            r_row_ok[i_wr_addr] <= 1'b1;
        end
    end

    // read port, a row written in the same cycle is passed straight through
    always_ff @(posedge i_clk) begin
        if (i_we && (i_wr_addr == i_rd_addr)) begin
            r_rd_row <= i_wr_row;
        end else if (r_row_ok[i_rd_addr]) begin
            r_rd_row <= mem[i_rd_addr];
        end else begin
            r_rd_row <= '0;
        end
    end

    assign o_rd_row = r_rd_row;

endmodule

[hw/rtl/cht_lookup.sv]
// ----------------------------------------------------------------------------
// cht_lookup
// Tag compare over all ways of a set, victim choice and row update.
// Holds the random replacement lfsr.
// ----------------------------------------------------------------------------
module cht_lookup (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  cht_pkg::t_cfg                 i_cfg,
    input  logic                          i_command,
    input  logic [cht_pkg::ADDR_W-1:0]    i_address,
    input  cht_pkg::t_row                 i_row,
    output cht_pkg::t_row                 o_row,
    output cht_pkg::t_result              o_result
);
    import cht_pkg::*;

    logic [LFSR_W-1:0]    r_lfsr;
    logic [LFSR_W-1:0]    n_lfsr;
    logic                 lfsr_upd;

    logic [WAYS-1:0]      way_en;
    logic [WAYS_LOG2-1:0] num_mask;
    logic [TAG_W-1:0]     tag;
    logic                 hit;
    logic [WAYS_LOG2-1:0] hit_way;
    logic                 has_inv;
    logic [WAYS_LOG2-1:0] inv_way;
    logic [AGE_W-1:0]     best_age;
    logic [WAYS_LOG2-1:0] lru_way;
    logic                 alloc;
    logic                 is_lru;
    logic                 is_rand;
    logic [WAYS_LOG2-1:0] victim;
    logic [WAYS_LOG2-1:0] touch_way;
    logic [AGE_W:0]       age_lim;
    t_row                 new_row;

    assign way_en   = way_mask(i_cfg);
    assign num_mask = way_num_mask(i_cfg);
    assign tag      = addr_tag(i_address, i_cfg);
    assign is_lru   = (i_cfg.policy == POL_LRU);
    assign is_rand  = (i_cfg.policy == POL_RANDOM);

    // galois step of the lfsr
    assign n_lfsr = {1'b0, r_lfsr[LFSR_W-1:1]} ^ (r_lfsr[0] ? LFSR_TAPS : '0);

    // tag compare and first-invalid search, lowest way wins
    always_comb begin
        hit     = 1'b0;
        hit_way = '0;
        has_inv = 1'b0;
        inv_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (way_en[w] && i_row.valid[w] && (i_row.tags[w] == tag)) begin
                hit     = 1'b1;
                hit_way = WAYS_LOG2'(w);
            end
            if (way_en[w] && !i_row.valid[w]) begin
                has_inv = 1'b1;
                inv_way = WAYS_LOG2'(w);
            end
        end
    end

    // oldest way, first one on a tie
    always_comb begin
        best_age = '0;
        lru_way  = '0;
        for (int w = 0; w < WAYS; w++) begin
            if (way_en[w] && (i_row.age[w] > best_age)) begin
                best_age = i_row.age[w];
                lru_way  = WAYS_LOG2'(w);
            end
        end
    end

    // victim choice
    always_comb begin
        alloc = !hit && !((i_command == CMD_WRITE) && i_cfg.write_through);
        if (has_inv) begin
            victim = inv_way;
        end else if (is_lru) begin
            victim = lru_way;
        end else if (is_rand) begin
            victim = n_lfsr[WAYS_LOG2-1:0] & num_mask;
        end else begin
            victim = i_row.fifo_ptr & num_mask;
        end
        lfsr_upd = alloc && !has_inv && is_rand;
    end

    // row update: allocation, lru ages, fifo pointer
    always_comb begin
        new_row   = i_row;
        touch_way = hit ? hit_way : victim;
        if (hit) begin
            age_lim = {1'b0, i_row.age[hit_way]};
        end else if (has_inv) begin
            age_lim = {1'b1, {AGE_W{1'b0}}};
        end else begin
            age_lim = {1'b0, best_age};
        end
        if (alloc) begin
            new_row.tags[victim]  = tag;
            new_row.valid[victim] = 1'b1;
        end
        if (is_lru && (hit || alloc)) begin
            for (int v = 0; v < WAYS; v++) begin
                if (way_en[v] && (WAYS_LOG2'(v) != touch_way) && i_row.valid[v] &&
                    ({1'b0, i_row.age[v]} < age_lim) && (i_row.age[v] != AGE_MAX)) begin
                    new_row.age[v] = i_row.age[v] + 1'b1;
                end
            end
            new_row.age[touch_way] = '0;
        end
        if (alloc && !has_inv && !is_lru && !is_rand) begin
            new_row.fifo_ptr = (victim + 1'b1) & num_mask;
        end
    end

    // lfsr moves only on a random choice
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lfsr <= LFSR_SEED;
        end else if (i_valid && lfsr_upd) begin
            r_lfsr <= n_lfsr;
        end
    end

    assign o_row              = new_row;
    assign o_result.hit       = hit;
    assign o_result.set_index = addr_set(i_address, i_cfg);
    assign o_result.tag       = tag;

endmodule

[hw/rtl/cache_hit_miss_tag_store.sv]
// ----------------------------------------------------------------------------
// cache_hit_miss_tag_store
// Set-associative cache tag store with fifo, lru or random replacement.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------
//  access   | start, busy                | i_command, i_address
//  result   | o_done (one-cycle strobe)  | o_hit, o_set_index, o_tag
//  config   | i_cfg_valid, o_cfg_ready   | i_cfg_index, i_cfg_data
//
//  One access is taken every cycle; it passes the input register and then the
//  result register before its strobe. The set row is
//  read from the row RAM at accept (registered read), compared and updated in
//  the next cycle, and written back at its end.
//  busy stays low; config is always ready.
//  Reset clears the row valid flops, so there is no clearing pass.
// ----------------------------------------------------------------------------
module cache_hit_miss_tag_store (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_command,
    input  logic [cht_pkg::ADDR_W-1:0]     i_address,
    output logic                           o_done,
    output logic                           o_hit,
    output logic [cht_pkg::SETS_LOG2-1:0]  o_set_index,
    output logic [cht_pkg::TAG_W-1:0]      o_tag,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [cht_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cht_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cht_pkg::*;

    t_cfg              cfg;
    t_row              rd_row;
    t_row              wr_row;
    t_result           result;
    logic              accept;

    logic              r_s1_valid;
    logic              r_s1_cmd;
    logic [ADDR_W-1:0] r_s1_addr;
    logic              r_done;
    t_result           r_result;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    cht_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_ready (o_cfg_ready),
        .o_cfg   (cfg)
    );

    // set row read addressed straight from the incoming beat
    cht_set_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (addr_set(i_address, cfg)),
        .i_we      (r_s1_valid),
        .i_wr_addr (result.set_index),
        .i_wr_row  (wr_row),
        .o_rd_row  (rd_row)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd  <= i_command;
            r_s1_addr <= i_address;
        end
    end

    cht_lookup u_lookup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (r_s1_valid),
        .i_cfg     (cfg),
        .i_command (r_s1_cmd),
        .i_address (r_s1_addr),
        .i_row     (rd_row),
        .o_row     (wr_row),
        .o_result  (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_result <= result;
        end
    end

    assign o_done      = r_done;
    assign o_hit       = r_result.hit;
    assign o_set_index = r_result.set_index;
    assign o_tag       = r_result.tag;

endmodule

[hw/rtl/cht_checker.sv]
// ----------------------------------------------------------------------------
// cht_checker
// Port-level checks on the tag store: result timing and repeat hits.
// ----------------------------------------------------------------------------
module cht_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          i_command,
    input logic [cht_pkg::ADDR_W-1:0]    i_address,
    input logic                          i_cfg_valid,
    input logic                          o_done,
    input logic                          o_hit
);
    import cht_pkg::*;

    // every accepted beat gives its result after the input and result registers
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("accepted beat produced no result");

    // no result without an earlier accepted beat
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result strobe without an accepted beat");

    // a read allocates, so the same address right behind it must hit
    a_repeat_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_command != CMD_WRITE) && !i_cfg_valid) ##1
        (start && !busy && !i_cfg_valid && (i_address == $past(i_address))) ##1
        !i_cfg_valid |-> ##1 o_hit)
        else $error("repeated read address missed");

endmodule

bind cache_hit_miss_tag_store cht_checker u_cht_checker (.*);

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cache tag store. Drives read and write accesses
// under many geometries, replacement policies and write modes, predicts hit,
// set and tag for every access, and checks each result strobe against it.
// ----------------------------------------------------------------------------
module tb;
    import cht_pkg::*;

    localparam logic [1:0] POL_SPARE = 2'd3;   // unused code, acts as fifo
    localparam logic       CMD_READ  = 1'b0;
    localparam int         PHASE_LEN = 90;
    localparam int         DRAIN_MAX = 1000;

    typedef enum int {IDLE_NONE, IDLE_FULL, IDLE_SPARSE} t_idle;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    logic                  i_command   = 1'b0;
    logic [ADDR_W-1:0]     i_address   = '0;
    logic                  o_done;
    logic                  o_hit;
    logic [SETS_LOG2-1:0]  o_set_index;
    logic [TAG_W-1:0]      o_tag;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    // shadow copy of the tag store
    logic [TAG_W-1:0]     shadow_tags  [SETS][WAYS];
    logic                 shadow_valid [SETS][WAYS];
    logic [AGE_W-1:0]     shadow_age   [SETS][WAYS];
    logic [WAYS_LOG2-1:0] shadow_fifo  [SETS];
    logic [LFSR_W-1:0]    shadow_lfsr;
    t_cfg                 shadow_cfg;

    t_result expected_lookups[$];
    t_idle   idle_mode = IDLE_FULL;

    int n_errors     = 0;
    int n_accesses   = 0;
    int n_results    = 0;
    int n_hits       = 0;
    int n_cfg_writes = 0;

    cache_hit_miss_tag_store uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_command   (i_command),
        .i_address   (i_address),
        .o_done      (o_done),
        .o_hit       (o_hit),
        .o_set_index (o_set_index),
        .o_tag       (o_tag),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // make way w the newest; valid ways younger than old_age grow older
    function automatic void age_touch(int s, int nways, int w, int old_age);
        for (int v = 0; v < nways; v++) begin
            if (v != w && shadow_valid[s][v] && shadow_age[s][v] < old_age
                    && shadow_age[s][v] < AGE_MAX) begin
                shadow_age[s][v] = shadow_age[s][v] + 1'b1;
            end
        end
        shadow_age[s][w] = '0;
    endfunction

    // look up one access in the shadow store and apply its allocation
    function automatic t_result lookup_and_allocate(logic cmd, logic [ADDR_W-1:0] addr);
        t_result           r;
        int                ib;
        int                wl;
        int                nways;
        int                s;
        int                hw;
        int                victim;
        int                best;
        bit                found;
        bit                lsb;
        logic [ADDR_W-1:0] tag;
        ib    = (shadow_cfg.set_bits > SETS_LOG2) ? SETS_LOG2 : shadow_cfg.set_bits;
        wl    = (shadow_cfg.ways_log2 > WAYS_LOG2) ? WAYS_LOG2 : shadow_cfg.ways_log2;
        nways = 1 << wl;
        s     = int'((addr >> shadow_cfg.blk_bits) & ((32'd1 << ib) - 32'd1));
        tag   = addr >> (shadow_cfg.blk_bits + ib);
        found = 1'b0;
        hw    = 0;
        for (int w = 0; w < nways; w++) begin
            if (!found && shadow_valid[s][w] && shadow_tags[s][w] == tag) begin
                found = 1'b1;
                hw    = w;
            end
        end
        if (found) begin
            if (shadow_cfg.policy == POL_LRU)
                age_touch(s, nways, hw, shadow_age[s][hw]);
        end else if (!(cmd == CMD_WRITE && shadow_cfg.write_through)) begin
            victim = nways;
            for (int w = nways - 1; w >= 0; w--) begin
                if (!shadow_valid[s][w])
                    victim = w;
            end
            if (victim < nways) begin
                if (shadow_cfg.policy == POL_LRU)
                    age_touch(s, nways, victim, 16);
            end else if (shadow_cfg.policy == POL_LRU) begin
                // first way with the largest age
                best   = 0;
                victim = 0;
                for (int w = 0; w < nways; w++) begin
                    if (shadow_age[s][w] > best) begin
                        best   = shadow_age[s][w];
                        victim = w;
                    end
                end
                age_touch(s, nways, victim, best);
            end else if (shadow_cfg.policy == POL_RANDOM) begin
                lsb         = shadow_lfsr[0];
                shadow_lfsr = shadow_lfsr >> 1;
                if (lsb)
                    shadow_lfsr = shadow_lfsr ^ LFSR_TAPS;
                victim = int'(shadow_lfsr) & (nways - 1);
            end else begin
                victim         = int'(shadow_fifo[s]) & (nways - 1);
                shadow_fifo[s] = WAYS_LOG2'((victim + 1) & (nways - 1));
            end
            shadow_tags[s][victim]  = tag;
            shadow_valid[s][victim] = 1'b1;
        end
        r.hit       = found;
        r.set_index = SETS_LOG2'(s);
        r.tag       = tag;
        return r;
    endfunction

    function automatic int draw_gap();
        case (idle_mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
            default:     return $urandom_range(0, 16);
        endcase
    endfunction

    // one access beat; start stays high afterwards for back-to-back beats
    task automatic send_access(logic cmd, logic [ADDR_W-1:0] addr);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_command <= cmd;
        i_address <= addr;
        do begin
            @(posedge i_clk);
        end while (busy);
        expected_lookups.insert(expected_lookups.size(), lookup_and_allocate(cmd, addr));
        n_accesses++;
    endtask

    // stop sending and wait for every outstanding result
    task automatic wait_drained();
        int guard;
        start <= 1'b0;
        guard = 0;
        while (expected_lookups.size() != 0 && guard < DRAIN_MAX) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (3) @(posedge i_clk);
    endtask

    // one config beat; valid is left high for the next one
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            CFG_BLK_BITS:      shadow_cfg.blk_bits      = data[3:0];
            CFG_SET_BITS:      shadow_cfg.set_bits      = data[2:0];
            CFG_WAYS_LOG2:     shadow_cfg.ways_log2     = data[1:0];
            CFG_POLICY:        shadow_cfg.policy        = data[1:0];
            CFG_WRITE_THROUGH: shadow_cfg.write_through = data[0];
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    // write all five registers once the store is quiet
    task automatic apply_config(t_cfg c);
        wait_drained();
        write_reg(CFG_BLK_BITS, c.blk_bits);
        write_reg(CFG_SET_BITS, c.set_bits);
        write_reg(CFG_WAYS_LOG2, c.ways_log2);
        write_reg(CFG_POLICY, c.policy);
        write_reg(CFG_WRITE_THROUGH, c.write_through);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_cfg random_geometry(logic [1:0] pol);
        t_cfg c;
        case ($urandom_range(0, 3))
            0:       c.blk_bits = 4'd0;
            1:       c.blk_bits = 4'd15;
            default: c.blk_bits = 4'($urandom_range(0, 15));
        endcase
        c.set_bits      = 3'($urandom_range(0, 7));
        c.ways_log2     = 2'($urandom_range(0, 3));
        c.policy        = pol;
        c.write_through = 1'($urandom_range(0, 1));
        return c;
    endfunction

    // configure, then a run of accesses over a few sets and a small tag pool
    task automatic run_phase(t_cfg c);
        logic [ADDR_W-1:0] tag_pool [12];
        int                set_pool [4];
        int                ib;
        int                sh;
        int                ntags;
        int                nsets;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] off_mask;
        apply_config(c);
        idle_mode = t_idle'($urandom_range(0, 2));
        ib        = (c.set_bits > SETS_LOG2) ? SETS_LOG2 : c.set_bits;
        sh        = c.blk_bits + ib;
        off_mask  = (32'd1 << c.blk_bits) - 32'd1;
        ntags     = (1 << c.ways_log2) + $urandom_range(1, 4);
        nsets     = $urandom_range(1, 4);
        for (int i = 0; i < 12; i++)
            tag_pool[i] = $urandom();
        for (int i = 0; i < 4; i++)
            set_pool[i] = $urandom_range(0, (1 << ib) - 1);
        for (int i = 0; i < PHASE_LEN; i++) begin
            if ($urandom_range(0, 99) < 85) begin
                addr = (tag_pool[$urandom_range(0, ntags - 1)] << sh)
                     | (ADDR_W'(set_pool[$urandom_range(0, nsets - 1)]) << c.blk_bits)
                     | ($urandom() & off_mask);
            end else begin
                addr = $urandom();
            end
            send_access(1'($urandom_range(0, 1)), addr);
        end
    endtask

    // reset values of the registers, hits within a block, both address extremes
    task automatic test_reset_geometry();
        idle_mode = IDLE_FULL;
        send_access(CMD_READ, 32'h0000_0000);
        send_access(CMD_READ, 32'h0000_000F);
        send_access(CMD_WRITE, 32'h0000_0000);
        send_access(CMD_READ, 32'hFFFF_FFFF);
        send_access(CMD_WRITE, 32'h0000_1230);
        send_access(CMD_READ, 32'h0000_1234);
    endtask

    // largest offset, saturated index, one way, spare policy code, write-through
    task automatic test_write_through_one_way();
        apply_config(t_cfg'{4'd15, 3'd7, 2'd0, POL_SPARE, 1'b1});
        send_access(CMD_WRITE, 32'h1234_5678);
        send_access(CMD_READ, 32'h1234_5678);
        send_access(CMD_WRITE, 32'h1234_5678);
        send_access(CMD_READ, 32'h9234_5678);
        send_access(CMD_READ, 32'h1234_5678);
    endtask

    // one set, two ways, lru order checked through eviction
    task automatic test_fully_associative_lru();
        apply_config(t_cfg'{4'd0, 3'd0, 2'd1, POL_LRU, 1'b0});
        send_access(CMD_READ, 32'h0000_0010);
        send_access(CMD_READ, 32'h0000_0020);
        send_access(CMD_READ, 32'h0000_0010);
        send_access(CMD_READ, 32'h0000_0030);
        send_access(CMD_READ, 32'h0000_0020);
        send_access(CMD_READ, 32'h0000_0030);
    endtask

    // fill all eight ways of the single set, then force random victims
    task automatic test_random_victim();
        apply_config(t_cfg'{4'd2, 3'd0, 2'd3, POL_RANDOM, 1'b0});
        for (int i = 1; i <= 8; i++)
            send_access(CMD_READ, ADDR_W'(i) << 2);
        for (int i = 9; i <= 16; i++)
            send_access(CMD_READ, ADDR_W'(i) << 2);
    endtask

    task automatic test_fifo_replacement();
        for (int p = 0; p < 4; p++)
            run_phase(random_geometry((p % 2 == 0) ? POL_FIFO : POL_SPARE));
    endtask

    task automatic test_lru_replacement();
        for (int p = 0; p < 4; p++)
            run_phase(random_geometry(POL_LRU));
    endtask

    task automatic test_random_replacement();
        for (int p = 0; p < 4; p++)
            run_phase(random_geometry(POL_RANDOM));
    endtask

    task automatic test_config_sweep();
        for (int p = 0; p < 5; p++)
            run_phase(random_geometry(2'($urandom_range(0, 3))));
    endtask

    // result checker
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_done) begin
            n_results++;
            if (o_hit === 1'b1)
                n_hits++;
            if (expected_lookups.size() == 0) begin
                $display("%0t: unexpected result hit=%0d set=%0d tag=%h",
                         $time, o_hit, o_set_index, o_tag);
                n_errors++;
            end else begin
                want = expected_lookups.pop_front();
                if (o_hit !== want.hit) begin
                    $display("%0t: hit mismatch, expected %0d actual %0d",
                             $time, want.hit, o_hit);
                    n_errors++;
                end
                if (o_set_index !== want.set_index) begin
                    $display("%0t: set mismatch, expected %0d actual %0d",
                             $time, want.set_index, o_set_index);
                    n_errors++;
                end
                if (o_tag !== want.tag) begin
                    $display("%0t: tag mismatch, expected %h actual %h",
                             $time, want.tag, o_tag);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        // shadow store after reset
        for (int s = 0; s < SETS; s++) begin
            shadow_fifo[s] = '0;
            for (int w = 0; w < WAYS; w++) begin
                shadow_tags[s][w]  = '0;
                shadow_valid[s][w] = 1'b0;
                shadow_age[s][w]   = '0;
            end
        end
        shadow_lfsr = LFSR_SEED;
        shadow_cfg  = t_cfg'{4'd4, 3'd6, 2'd3, POL_FIFO, 1'b0};

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_geometry();
        test_write_through_one_way();
        test_fully_associative_lru();
        test_random_victim();
        test_fifo_replacement();
        test_lru_replacement();
        test_random_replacement();
        test_config_sweep();

        wait_drained();
        if (expected_lookups.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_lookups.size());
            n_errors++;
        end

        $display("covered %0d accesses (%0d hits, %0d misses), %0d register writes",
                 n_accesses, n_hits, n_results - n_hits, n_cfg_writes);
        $display("fifo, lru and random replacement, write-back and write-through");
        if (n_errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("%0t: timeout", $time);
        $display("tb: FAIL");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/cht_pkg.sv
hw/rtl/cht_cfg_regs.sv
hw/rtl/cht_set_ram.sv
hw/rtl/cht_lookup.sv
hw/rtl/cache_hit_miss_tag_store.sv
hw/rtl/cht_checker.sv
tb/tb.sv
